// ===== hdl/wmfi_pkg.sv =====
// Shared types and constants for the windowed motion flash indicator.
// No dependencies; used by the top level, its port checker and the testbench.
package wmfi_pkg;

	// Fixed field widths
	localparam int THR_W = 34;
	localparam int REG_W = 16;
	localparam int IDX_W = 3;
	localparam int ACC_W = 16;

	// Operation codes
	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_TICK   = 1'b1;

	// Configuration register indexes
	localparam logic [IDX_W-1:0] REG_THRESHOLD_SQ = 3'd0;
	localparam logic [IDX_W-1:0] REG_INTERVAL_MS  = 3'd1;
	localparam logic [IDX_W-1:0] REG_WINDOW_MS    = 3'd2;
	localparam logic [IDX_W-1:0] REG_FLASH_MS     = 3'd3;

	// Register reset values: 0.75 g at 8192 LSB/g is 6144 counts, squared
	localparam logic [THR_W-1:0] THRESHOLD_SQ_RST = 34'd37748736;
	localparam logic [REG_W-1:0] INTERVAL_MS_RST  = 16'd1000;
	localparam logic [REG_W-1:0] WINDOW_MS_RST    = 16'd250;
	localparam logic [REG_W-1:0] FLASH_MS_RST     = 16'd100;

	// Indicator light state
	typedef struct packed {
		logic green;
		logic red;
	} lights_t;

endpackage

// ===== hdl/windowed_motion_flash_indicator.sv =====
// Windowed motion flash indicator: top level with input and result registers.
// Uses wmfi_pkg for codes, widths and register reset values.
// A request is taken into the input register; its result is then held in the result register.
// Throughput: one request per cycle while out_stall is low; all work sits between the input
// register and the result register (three small squarers, a sum and compares).
// Reset (arst_n low, asynchronous): registers take their default values,
// timers and flags clear, lights go off and both pipeline stages empty.
module windowed_motion_flash_indicator #(
	parameter int SAMPLE_BITS = 16,
	parameter int TIMER_BITS  = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// input channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          operation,
	input  logic [wmfi_pkg::ACC_W-1:0]    accel_x,
	input  logic [wmfi_pkg::ACC_W-1:0]    accel_y,
	input  logic [wmfi_pkg::ACC_W-1:0]    accel_z,
	// result channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          green_on,
	output logic                          red_on,
	output logic [wmfi_pkg::THR_W-1:0]    distance_sq,
	output logic                          over_threshold,
	// configuration write channel
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [wmfi_pkg::IDX_W-1:0]    cfg_index,
	input  logic [wmfi_pkg::THR_W-1:0]    cfg_data
);

	localparam int DIFF_W = SAMPLE_BITS + 1;
	localparam int SQ_W   = 2 * DIFF_W;
	localparam int SUM_W  = SQ_W + 2;
	localparam int CMP_W  = (TIMER_BITS > wmfi_pkg::REG_W) ? TIMER_BITS : wmfi_pkg::REG_W;
	localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

	// Configuration registers
	logic [wmfi_pkg::THR_W-1:0] thr_q;
	logic [wmfi_pkg::REG_W-1:0] interval_q;
	logic [wmfi_pkg::REG_W-1:0] window_q;
	logic [wmfi_pkg::REG_W-1:0] flash_len_q;

	// Block state
	logic [SAMPLE_BITS-1:0] prev_x_q, prev_y_q, prev_z_q;
	logic                   first_q;
	logic [TIMER_BITS-1:0]  intv_el_q;
	logic [TIMER_BITS-1:0]  flash_el_q;
	logic                   flashing_q;
	logic                   motion_q;
	wmfi_pkg::lights_t      lights_q;

	// Input stage
	logic                   valid_s1;
	logic                   op_s1;
	logic [SAMPLE_BITS-1:0] x_s1, y_s1, z_s1;

	// Result stage
	logic                       valid_s2;
	wmfi_pkg::lights_t          lights_s2;
	logic [wmfi_pkg::THR_W-1:0] dist_s2;
	logic                       over_s2;

	// Handshake
	logic in_fire;
	logic fire;

	// Distance datapath
	logic signed [DIFF_W-1:0] dx, dy, dz;
	logic        [DIFF_W-1:0] ax, ay, az;
	logic        [SQ_W-1:0]   sqx, sqy, sqz;
	logic        [SUM_W-1:0]  sum;
	logic [wmfi_pkg::THR_W-1:0] sum_t;

	// Next-state values
	logic [TIMER_BITS-1:0]      intv_el_d;
	logic [TIMER_BITS-1:0]      flash_el_d;
	logic                       flashing_d;
	logic                       motion_d;
	wmfi_pkg::lights_t          lights_d;
	logic [wmfi_pkg::THR_W-1:0] dist_d;
	logic                       over_d;
	logic [wmfi_pkg::REG_W-1:0] win_start;
	logic [CMP_W-1:0]           intv_el_x;

	function automatic logic [TIMER_BITS-1:0] timer_inc(input logic [TIMER_BITS-1:0] t);
		return (t == TIMER_MAX) ? t : t + 1'b1;
	endfunction

	// Stage s1 moves on when the result register is empty or being drained
	assign fire      = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall  = valid_s1 && !fire;
	assign in_fire   = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	// Squared distance to the previous sample
	assign dx  = $signed({x_s1[SAMPLE_BITS-1], x_s1}) - $signed({prev_x_q[SAMPLE_BITS-1], prev_x_q});
	assign dy  = $signed({y_s1[SAMPLE_BITS-1], y_s1}) - $signed({prev_y_q[SAMPLE_BITS-1], prev_y_q});
	assign dz  = $signed({z_s1[SAMPLE_BITS-1], z_s1}) - $signed({prev_z_q[SAMPLE_BITS-1], prev_z_q});
	assign ax  = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
	assign ay  = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
	assign az  = dz[DIFF_W-1] ? DIFF_W'(-dz) : DIFF_W'(dz);
	assign sqx = SQ_W'(ax) * SQ_W'(ax);
	assign sqy = SQ_W'(ay) * SQ_W'(ay);
	assign sqz = SQ_W'(az) * SQ_W'(az);
	assign sum = SUM_W'(sqx) + SUM_W'(sqy) + SUM_W'(sqz);
	// the true sum always fits in the distance field
	assign sum_t = wmfi_pkg::THR_W'(sum);

	// Window start saturates at zero when the window covers the whole interval
	assign win_start = (window_q >= interval_q) ? '0 : interval_q - window_q;

	// Per-request state update: timers, window test, boundary, flash end
	always_comb begin
		intv_el_d  = intv_el_q;
		flash_el_d = flash_el_q;
		flashing_d = flashing_q;
		motion_d   = motion_q;
		lights_d   = lights_q;
		dist_d     = '0;
		over_d     = 1'b0;
		intv_el_x  = CMP_W'(intv_el_q);
		if (op_s1 == wmfi_pkg::OP_TICK) begin
			intv_el_d = timer_inc(intv_el_q);
			if (flashing_q) begin
				flash_el_d = timer_inc(flash_el_q);
			end
		end else begin
			if (!first_q) begin
				dist_d = sum_t;
			end
			if (intv_el_x >= CMP_W'(win_start) && intv_el_x < CMP_W'(interval_q) &&
				dist_d > thr_q) begin
				over_d   = 1'b1;
				motion_d = 1'b1;
			end
		end
		// interval boundary, held off while a flash runs
		if (CMP_W'(intv_el_d) >= CMP_W'(interval_q) && !flashing_d) begin
			lights_d.green = motion_d;
			lights_d.red   = !motion_d;
			flashing_d     = 1'b1;
			flash_el_d     = '0;
			motion_d       = 1'b0;
			intv_el_d      = TIMER_BITS'(CMP_W'(intv_el_d) - CMP_W'(interval_q));
		end
		// flash end
		if (flashing_d && CMP_W'(flash_el_d) >= CMP_W'(flash_len_q)) begin
			lights_d   = '0;
			flashing_d = 1'b0;
		end
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q       <= wmfi_pkg::THRESHOLD_SQ_RST;
			interval_q  <= wmfi_pkg::INTERVAL_MS_RST;
			window_q    <= wmfi_pkg::WINDOW_MS_RST;
			flash_len_q <= wmfi_pkg::FLASH_MS_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				wmfi_pkg::REG_THRESHOLD_SQ: thr_q       <= cfg_data;
				wmfi_pkg::REG_INTERVAL_MS:  interval_q  <= cfg_data[wmfi_pkg::REG_W-1:0];
				wmfi_pkg::REG_WINDOW_MS:    window_q    <= cfg_data[wmfi_pkg::REG_W-1:0];
				wmfi_pkg::REG_FLASH_MS:     flash_len_q <= cfg_data[wmfi_pkg::REG_W-1:0];
				default: ;
			endcase
		end
	end

	// Control state and stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			first_q    <= 1'b1;
			intv_el_q  <= '0;
			flash_el_q <= '0;
			flashing_q <= 1'b0;
			motion_q   <= 1'b0;
			lights_q   <= '0;
		end else begin
			if (in_fire) begin
				valid_s1 <= 1'b1;
			end else if (fire) begin
				valid_s1 <= 1'b0;
			end
			if (fire) begin
				valid_s2 <= 1'b1;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
			if (fire) begin
				if (op_s1 == wmfi_pkg::OP_SAMPLE) begin
					first_q <= 1'b0;
				end
				intv_el_q  <= intv_el_d;
				flash_el_q <= flash_el_d;
				flashing_q <= flashing_d;
				motion_q   <= motion_d;
				lights_q   <= lights_d;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_s1 <= operation;
			x_s1  <= accel_x[SAMPLE_BITS-1:0];
			y_s1  <= accel_y[SAMPLE_BITS-1:0];
			z_s1  <= accel_z[SAMPLE_BITS-1:0];
		end
		if (fire) begin
			lights_s2 <= lights_d;
			dist_s2   <= dist_d;
			over_s2   <= over_d;
			if (op_s1 == wmfi_pkg::OP_SAMPLE) begin
				prev_x_q <= x_s1;
				prev_y_q <= y_s1;
				prev_z_q <= z_s1;
			end
		end
	end

	assign out_valid      = valid_s2;
	assign green_on       = lights_s2.green;
	assign red_on         = lights_s2.red;
	assign distance_sq    = dist_s2;
	assign over_threshold = over_s2;

endmodule

// ===== hdl/wmfi_checker.sv =====
// Port-level checker for the windowed motion flash indicator, and its bind.
// Uses wmfi_pkg for field widths.
module wmfi_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_stall,
	input logic                       operation,
	input logic [wmfi_pkg::ACC_W-1:0] accel_x,
	input logic [wmfi_pkg::ACC_W-1:0] accel_y,
	input logic [wmfi_pkg::ACC_W-1:0] accel_z,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic                       green_on,
	input logic                       red_on,
	input logic [wmfi_pkg::THR_W-1:0] distance_sq,
	input logic                       over_threshold,
	input logic                       cfg_valid,
	input logic                       cfg_ready,
	input logic [wmfi_pkg::IDX_W-1:0] cfg_index,
	input logic [wmfi_pkg::THR_W-1:0] cfg_data
);

	// Only one light at a time
	a_one_light: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(green_on && red_on))
		else $error("green and red lit together");

	// A request over threshold has a nonzero distance
	a_over_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && over_threshold) |-> (distance_sq != '0))
		else $error("over_threshold with zero distance");

	// With the result register empty, the input side never stalls
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty result register");

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(distance_sq) &&
			$stable(green_on) && $stable(red_on) && $stable(over_threshold)))
		else $error("stalled result changed");

endmodule

bind windowed_motion_flash_indicator wmfi_checker u_wmfi_checker (.*);

// ===== dv/testbench.sv =====
// Self-checking testbench for windowed_motion_flash_indicator: directed and random
// samples and ticks, checked against a cycle-free model of the lights and distances.
// Depends on wmfi_pkg and the top level from hdl/.
module testbench;

	localparam int THR_W = wmfi_pkg::THR_W;
	localparam int REG_W = wmfi_pkg::REG_W;
	localparam int IDX_W = wmfi_pkg::IDX_W;
	localparam int ACC_W = wmfi_pkg::ACC_W;
	localparam int TIMER_BITS = 16;
	localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;
	localparam logic [THR_W-1:0] THR_MAX_DIST = 34'd12884508675;
	localparam int LONG_HOLD_CYCLES = 60;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int RANDOM_PHASE_ITEMS = 75;

	// Sample x values around a fixed y = z = -1 point (threshold 100 tests)
	localparam logic [ACC_W-1:0] ALL_ONES = 16'hFFFF;
	localparam logic [ACC_W-1:0] X_HOME = 16'hFFFF;
	localparam logic [ACC_W-1:0] X_FAR = 16'd10;
	localparam logic [ACC_W-1:0] X_EQUAL = 16'd9;

	typedef struct packed {
		logic green;
		logic red;
		logic [THR_W-1:0] sq_dist;
		logic over;
	} indication_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic operation = wmfi_pkg::OP_SAMPLE;
	logic [ACC_W-1:0] accel_x = '0;
	logic [ACC_W-1:0] accel_y = '0;
	logic [ACC_W-1:0] accel_z = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic green_on;
	logic red_on;
	logic [THR_W-1:0] distance_sq;
	logic over_threshold;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [THR_W-1:0] cfg_data = '0;

	// Model copy of registers and state
	logic [THR_W-1:0] thr_sq = wmfi_pkg::THRESHOLD_SQ_RST;
	logic [REG_W-1:0] interval_len = wmfi_pkg::INTERVAL_MS_RST;
	logic [REG_W-1:0] window_len = wmfi_pkg::WINDOW_MS_RST;
	logic [REG_W-1:0] flash_len = wmfi_pkg::FLASH_MS_RST;
	logic signed [ACC_W-1:0] last_pos [3] = '{default: '0};
	logic awaiting_first = 1'b1;
	logic [TIMER_BITS-1:0] interval_ticks = '0;
	logic [TIMER_BITS-1:0] flash_ticks = '0;
	logic flash_running = 1'b0;
	logic motion_flag = 1'b0;
	logic green_lit = 1'b0;
	logic red_lit = 1'b0;

	indication_t pending_indications [$];
	int mismatches = 0;
	int cycle_count = 0;
	bit idle_on = 1'b1;
	bit long_hold_req = 1'b0;
	int hold_left = 0;
	int stall_left = 0;

	windowed_motion_flash_indicator DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.accel_x(accel_x),
		.accel_y(accel_y),
		.accel_z(accel_z),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.green_on(green_on),
		.red_on(red_on),
		.distance_sq(distance_sq),
		.over_threshold(over_threshold),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Advance the model by one sample or tick and return the lights it shows after
	function automatic indication_t indicator_step(input logic op, input logic [ACC_W-1:0] x,
			input logic [ACC_W-1:0] y, input logic [ACC_W-1:0] z);
		indication_t r;
		logic [ACC_W-1:0] cur [3];
		longint d;
		longint sum;
		logic [REG_W-1:0] win_start;
		r = '0;
		if (op == wmfi_pkg::OP_TICK) begin
			if (interval_ticks != TIMER_MAX)
				interval_ticks++;
			if (flash_running && flash_ticks != TIMER_MAX)
				flash_ticks++;
		end else begin
			cur = '{x, y, z};
			sum = 0;
			for (int i = 0; i < 3; i++) begin
				d = longint'($signed(cur[i])) - longint'(last_pos[i]);
				sum += d * d;
				last_pos[i] = cur[i];
			end
			if (awaiting_first)
				awaiting_first = 1'b0;
			else
				r.sq_dist = sum[THR_W-1:0];
			// window is the tail of the interval; too long a window covers all of it
			win_start = (window_len >= interval_len) ? '0 : interval_len - window_len;
			if (interval_ticks >= win_start && interval_ticks < interval_len &&
					r.sq_dist > thr_sq) begin
				r.over = 1'b1;
				motion_flag = 1'b1;
			end
		end
		// interval boundary, held off while a light is on
		if (interval_ticks >= interval_len && !flash_running) begin
			green_lit = motion_flag;
			red_lit = !motion_flag;
			flash_running = 1'b1;
			flash_ticks = '0;
			motion_flag = 1'b0;
			interval_ticks -= interval_len;
		end
		if (flash_running && flash_ticks >= flash_len) begin
			green_lit = 1'b0;
			red_lit = 1'b0;
			flash_running = 1'b0;
		end
		r.green = green_lit;
		r.red = red_lit;
		return r;
	endfunction

	task automatic report_mismatch(input string field, input logic [THR_W-1:0] want,
			input logic [THR_W-1:0] got);
		$display("%0t: %s expected %0d got %0d", $time, field, want, got);
		mismatches++;
	endtask

	// Result checker: every accepted result against the oldest expectation
	always @(posedge clk) begin : check_result
		indication_t want;
		indication_t got;
		if (arst_n && out_valid && !out_stall) begin
			got = {green_on, red_on, distance_sq, over_threshold};
			if (pending_indications.size() == 0) begin
				$display("%0t: unexpected result green %0b red %0b dist %0d over %0b",
					$time, green_on, red_on, distance_sq, over_threshold);
				mismatches++;
			end else begin
				want = pending_indications.pop_front();
				if (got.green !== want.green)
					report_mismatch("green_on", THR_W'(want.green), THR_W'(got.green));
				if (got.red !== want.red)
					report_mismatch("red_on", THR_W'(want.red), THR_W'(got.red));
				if (got.sq_dist !== want.sq_dist)
					report_mismatch("distance_sq", want.sq_dist, got.sq_dist);
				if (got.over !== want.over)
					report_mismatch("over_threshold", THR_W'(want.over), THR_W'(got.over));
			end
		end
	end

	// Result side: random stall bursts, plus one long hold on request
	always @(negedge clk) begin
		if (long_hold_req) begin
			long_hold_req = 1'b0;
			hold_left = LONG_HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(0, 18);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Offer one request; returns at the edge where it is taken
	task automatic send_event(input logic op, input logic [ACC_W-1:0] x,
			input logic [ACC_W-1:0] y, input logic [ACC_W-1:0] z);
		int gap;
		gap = (idle_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 19) : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		accel_x <= x;
		accel_y <= y;
		accel_z <= z;
		do @(posedge clk); while (in_stall);
		pending_indications.push_back(indicator_step(op, x, y, z));
	endtask

	task automatic send_ticks(input int count);
		repeat (count)
			send_event(wmfi_pkg::OP_TICK, 16'($urandom), 16'($urandom), 16'($urandom));
	endtask

	task automatic send_x_sample(input logic [ACC_W-1:0] x);
		send_event(wmfi_pkg::OP_SAMPLE, x, ALL_ONES, ALL_ONES);
	endtask

	task automatic send_random_event();
		logic [ACC_W-1:0] v [3];
		int span;
		span = 8 << (3 * $urandom_range(0, 3));
		for (int i = 0; i < 3; i++) begin
			case ($urandom_range(0, 3))
				0: v[i] = 16'($urandom);
				1: v[i] = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
				2: v[i] = 16'($urandom_range(0, 2)) - 16'd1;
				default: v[i] = 16'(last_pos[i] + $urandom_range(0, 2 * span) - span);
			endcase
		end
		send_event($urandom_range(0, 1) ? wmfi_pkg::OP_TICK : wmfi_pkg::OP_SAMPLE,
			v[0], v[1], v[2]);
	endtask

	// Register write; only called while nothing is in flight
	task automatic write_register(input logic [IDX_W-1:0] idx, input logic [THR_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			wmfi_pkg::REG_THRESHOLD_SQ: thr_sq = data;
			wmfi_pkg::REG_INTERVAL_MS: interval_len = data[REG_W-1:0];
			wmfi_pkg::REG_WINDOW_MS: window_len = data[REG_W-1:0];
			wmfi_pkg::REG_FLASH_MS: flash_len = data[REG_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Stop offering, wait for every expected result, then a short settle
	task automatic drain_indications();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_indications.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// First sample after reset, full-scale jumps, repeats
	task automatic test_sample_extremes();
		send_event(wmfi_pkg::OP_SAMPLE, 16'h8000, 16'h7FFF, 16'h8000);
		send_event(wmfi_pkg::OP_SAMPLE, 16'h7FFF, 16'h8000, 16'h7FFF);
		send_event(wmfi_pkg::OP_SAMPLE, 16'h7FFF, 16'h8000, 16'h7FFF);
		send_event(wmfi_pkg::OP_SAMPLE, 16'h0000, 16'h0000, 16'h0000);
		send_ticks(2);
		send_event(wmfi_pkg::OP_SAMPLE, ALL_ONES, ALL_ONES, ALL_ONES);
		drain_indications();
	endtask

	// Window edges and the strict threshold compare; 6-tick interval, window at 3..5
	task automatic test_window_edges();
		write_register(wmfi_pkg::REG_THRESHOLD_SQ, 34'd100);
		write_register(wmfi_pkg::REG_INTERVAL_MS, 34'd6);
		write_register(wmfi_pkg::REG_WINDOW_MS, 34'd3);
		write_register(wmfi_pkg::REG_FLASH_MS, 34'd2);
		send_x_sample(X_FAR);
		send_x_sample(X_HOME);
		send_ticks(1);
		send_x_sample(X_EQUAL);
		send_x_sample(X_HOME);
		send_x_sample(X_FAR);
		send_ticks(2);
		send_x_sample(X_HOME);
		send_ticks(1);
		send_x_sample(X_FAR);
		send_ticks(8);
		drain_indications();
	endtask

	task automatic test_special_cases();
		// window longer than the interval: the whole interval counts
		write_register(wmfi_pkg::REG_WINDOW_MS, 34'hFFFF);
		send_x_sample(X_HOME);
		send_ticks(6);
		drain_indications();
		// flash outlasts the interval, so the boundary waits for it
		write_register(wmfi_pkg::REG_INTERVAL_MS, 34'd2);
		write_register(wmfi_pkg::REG_FLASH_MS, 34'd5);
		send_x_sample(X_FAR);
		send_ticks(7);
		drain_indications();
		// zero flash: light goes on and off within one item
		write_register(wmfi_pkg::REG_FLASH_MS, '0);
		send_ticks(3);
		drain_indications();
		// zero interval: boundary on every idle item, no sample in window
		write_register(wmfi_pkg::REG_INTERVAL_MS, '0);
		send_x_sample(X_HOME);
		send_ticks(1);
		drain_indications();
		write_register(wmfi_pkg::REG_FLASH_MS, 34'd1);
		send_x_sample(X_FAR);
		send_x_sample(X_HOME);
		send_ticks(2);
		send_x_sample(X_FAR);
		drain_indications();
		// zero threshold; upper data bits of a 16-bit register are dropped
		write_register(wmfi_pkg::REG_THRESHOLD_SQ, '0);
		write_register(wmfi_pkg::REG_INTERVAL_MS, {18'h3FFFF, 16'd6});
		write_register(wmfi_pkg::REG_WINDOW_MS, 34'd6);
		send_x_sample(X_FAR);
		send_x_sample(16'd11);
		drain_indications();
		// threshold at the largest possible distance: never exceeded
		write_register(wmfi_pkg::REG_THRESHOLD_SQ, THR_MAX_DIST);
		send_event(wmfi_pkg::OP_SAMPLE, 16'h7FFF, 16'h7FFF, 16'h7FFF);
		send_event(wmfi_pkg::OP_SAMPLE, 16'h8000, 16'h8000, 16'h8000);
		drain_indications();
		// writes to unused indexes change nothing
		for (int idx = wmfi_pkg::REG_FLASH_MS + 1; idx < (1 << IDX_W); idx++)
			write_register(IDX_W'(idx), {2'($urandom), 32'($urandom)});
		send_event(wmfi_pkg::OP_SAMPLE, 16'h7FFF, 16'h7FFF, 16'h7FFF);
		send_ticks(2);
		drain_indications();
	endtask

	// Reset register values: a full-scale jump early in the interval is outside the window
	task automatic test_default_interval();
		write_register(wmfi_pkg::REG_THRESHOLD_SQ, wmfi_pkg::THRESHOLD_SQ_RST);
		write_register(wmfi_pkg::REG_INTERVAL_MS, THR_W'(wmfi_pkg::INTERVAL_MS_RST));
		write_register(wmfi_pkg::REG_WINDOW_MS, THR_W'(wmfi_pkg::WINDOW_MS_RST));
		write_register(wmfi_pkg::REG_FLASH_MS, THR_W'(wmfi_pkg::FLASH_MS_RST));
		send_event(wmfi_pkg::OP_SAMPLE, 16'h7FFF, 16'h7FFF, 16'h7FFF);
		send_event(wmfi_pkg::OP_SAMPLE, 16'h8000, 16'h8000, 16'h8000);
		send_ticks(10);
		send_event(wmfi_pkg::OP_SAMPLE, 16'h7FFF, 16'h7FFF, 16'h7FFF);
		drain_indications();
	endtask

	// Result side holds off while requests keep coming, so the input stalls
	task automatic test_backpressure();
		idle_on = 1'b0;
		write_register(wmfi_pkg::REG_FLASH_MS, 34'd3);
		write_register(wmfi_pkg::REG_INTERVAL_MS, 34'd5);
		long_hold_req = 1'b1;
		repeat (40) send_random_event();
		drain_indications();
	endtask

	task automatic test_random_phases();
		logic [THR_W-1:0] thr;
		logic [REG_W-1:0] iv;
		logic [REG_W-1:0] wv;
		logic [REG_W-1:0] fv;
		for (int phase = 0; phase < 8; phase++) begin
			// a quiet phase in the middle, and two at the end
			idle_on = (phase < 6) && (phase != 2);
			case ($urandom_range(0, 5))
				0: thr = '0;
				1: thr = THR_MAX_DIST;
				2: thr = {2'($urandom_range(0, 2)), 32'($urandom)};
				default: thr = THR_W'($urandom_range(0, 3 * 4096 * 4096));
			endcase
			if (thr > THR_MAX_DIST)
				thr = THR_MAX_DIST;
			iv = ($urandom_range(0, 5) == 0) ? 16'hFFFF : 16'($urandom_range(1, 24));
			wv = ($urandom_range(0, 5) == 0) ? 16'($urandom_range(0, 1) * 16'hFFFF) :
				16'($urandom_range(0, 24));
			fv = ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom_range(1, 6));
			if (phase == 1) begin
				iv = 16'd1;
				wv = '0;
				fv = 16'd1;
			end else if (phase == 4) begin
				iv = 16'hFFFF;
				wv = 16'hFFFF;
				fv = 16'hFFFF;
			end
			write_register(wmfi_pkg::REG_THRESHOLD_SQ, thr);
			write_register(wmfi_pkg::REG_INTERVAL_MS, THR_W'(iv));
			write_register(wmfi_pkg::REG_WINDOW_MS, THR_W'(wv));
			write_register(wmfi_pkg::REG_FLASH_MS, THR_W'(fv));
			repeat (RANDOM_PHASE_ITEMS) send_random_event();
			drain_indications();
		end
	endtask

	initial begin
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		test_sample_extremes();
		test_window_edges();
		test_special_cases();
		test_default_interval();
		test_backpressure();
		test_random_phases();
		drain_indications();
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/wmfi_pkg.sv
hdl/windowed_motion_flash_indicator.sv
hdl/wmfi_checker.sv
dv/testbench.sv
